[rtl/core/n2a_pkg.sv]
package n2a_pkg;

	// format codes
	typedef enum logic [1:0] {
		KIND_DEC  = 2'd0,
		KIND_HEX  = 2'd1,
		KIND_BIN  = 2'd2,
		KIND_BOOL = 2'd3
	} kind_t;

	// boolean text styles
	localparam logic [1:0] STYLE_TRUE_FALSE = 2'd0;
	localparam logic [1:0] STYLE_YES_NO     = 2'd1;
	localparam logic [1:0] STYLE_T_F        = 2'd2;

	localparam int MAX_CHARS = 10;
	localparam int NUM_DIGITS = 5;

	// decimal weights
	localparam logic [16:0] DEC_W4 = 17'd10000;
	localparam logic [16:0] DEC_W3 = 17'd1000;
	localparam logic [16:0] DEC_W2 = 17'd100;
	localparam logic [16:0] DEC_W1 = 17'd10;

	// ascii codes
	localparam logic [6:0] CH_0     = 7'h30;
	localparam logic [6:0] CH_1     = 7'h31;
	localparam logic [6:0] CH_A     = 7'h41;
	localparam logic [6:0] CH_MINUS = 7'h2D;
	localparam logic [6:0] CH_PLUS  = 7'h2B;
	localparam logic [6:0] CH_POINT = 7'h2E;
	localparam logic [6:0] CH_LC_X  = 7'h78;
	localparam logic [6:0] CH_LC_B  = 7'h62;
	localparam logic [6:0] CH_UC_T  = 7'h54;
	localparam logic [6:0] CH_UC_F  = 7'h46;
	localparam logic [6:0] CH_UC_Y  = 7'h59;
	localparam logic [6:0] CH_UC_N  = 7'h4E;
	localparam logic [6:0] CH_LC_R  = 7'h72;
	localparam logic [6:0] CH_LC_U  = 7'h75;
	localparam logic [6:0] CH_LC_E  = 7'h65;
	localparam logic [6:0] CH_LC_A  = 7'h61;
	localparam logic [6:0] CH_LC_L  = 7'h6C;
	localparam logic [6:0] CH_LC_S  = 7'h73;
	localparam logic [6:0] CH_LC_O  = 7'h6F;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] value;
		logic        force_sign;
		logic        leading_zeros;
		logic [1:0]  decimal_places;
		logic        hex_prefix;
		logic        hex_byte;
		logic        binary_prefix;
		logic [1:0]  bool_style;
	} fmt_t;

	typedef struct packed {
		fmt_t                          f;
		logic                          neg;
		logic [15:0]                   rem;
		logic [NUM_DIGITS-1:0][3:0]    dig;
	} stage_t;

	typedef logic [MAX_CHARS-1:0][6:0] char_buf_t;

	// one restoring decimal step: {digit, remainder} of r against weight w
	function automatic logic [19:0] dec_step(input logic [15:0] r, input logic [16:0] w);
		logic [3:0]  d;
		logic [16:0] sub;
		d = '0;
		sub = '0;
		for (int k = 1; k <= 9; k++) begin
			if ({1'b0, r} >= 17'(17'(k) * w)) begin
				d = 4'(k);
				sub = 17'(17'(k) * w);
			end
		end
		return {d, 16'({1'b0, r} - sub)};
	endfunction

	function automatic logic [6:0] hex_char(input logic [3:0] nib);
		if (nib <= 4'd9)
			return 7'(CH_0 + {3'b000, nib});
		else
			return 7'(CH_A + {3'b000, nib} - 7'd10);
	endfunction

endpackage

[rtl/core/number_to_ascii_formatter.sv]
// number to ascii text formatter
//
// input channel: a word (kind, value and the format fields) is taken at a
// rising edge where start is high and busy is low. busy only rises while
// the pipeline is full behind a long text still being sent.
// output channel: one character at a time on char_code, with strobe high
// for exactly one cycle; last marks the final character of a value's text.
// the receiver cannot hold characters off, so nothing is ever dropped here.
//
// pipeline: s1 sign and magnitude, s2 ten-thousands digit, s3 thousands,
// s4 hundreds, s5 tens and ones, s6 character assembly, then a shift
// register that sends one character per cycle into the output register.
// path: a word passes s1 to s6, the character shifter and the output
// register before its first character is on the ports.
// text length: 1 to 10 characters; the character shifter sets the rate,
// and back-to-back values leave no gap.
//
// reset: all valid bits and the shifter count clear, strobe is low, busy
// is low; payload registers are not reset.
module number_to_ascii_formatter
	import n2a_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  kind,
	input  logic [15:0] value,
	input  logic        unsigned_mode,
	input  logic        force_sign,
	input  logic        leading_zeros,
	input  logic [1:0]  decimal_places,
	input  logic        hex_prefix,
	input  logic        hex_byte,
	input  logic        binary_prefix,
	input  logic [1:0]  bool_style,
	output logic        strobe,
	output logic [6:0]  char_code,
	output logic        last
);

	// stage valid bits
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	// stage payloads
	stage_t st_s1, st_s2, st_s3, st_s4, st_s5;
	char_buf_t chr_s6;
	logic [3:0] len_s6;

	// character shifter
	char_buf_t chr_q;
	logic [3:0] rem_q;

	// output register
	logic strobe_q;
	logic [6:0] char_code_q;
	logic last_q;

	// stall chain: a stage moves when its successor is free or moving
	logic ser_take;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6;
	logic accept;

	assign ser_take = (rem_q <= 4'd1);
	assign rdy_s6 = !v_s6 || ser_take;
	assign rdy_s5 = !v_s5 || rdy_s6;
	assign rdy_s4 = !v_s4 || rdy_s5;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;

	assign busy = !rdy_s1;
	assign accept = start && rdy_s1;

	// stage 1: sign and magnitude
	stage_t nx_s1;
	always_comb begin
		nx_s1 = '0;
		nx_s1.f.kind = kind_t'(kind);
		nx_s1.f.value = value;
		nx_s1.f.force_sign = force_sign;
		nx_s1.f.leading_zeros = leading_zeros;
		nx_s1.f.decimal_places = decimal_places;
		nx_s1.f.hex_prefix = hex_prefix;
		nx_s1.f.hex_byte = hex_byte;
		nx_s1.f.binary_prefix = binary_prefix;
		nx_s1.f.bool_style = bool_style;
		nx_s1.neg = !unsigned_mode && value[15];
		// -32768 negates to 0x8000, which is the right magnitude
		nx_s1.rem = nx_s1.neg ? 16'(~value + 16'd1) : value;
	end

	// stages 2 to 5: one decimal weight each, tens and ones share the last
	stage_t nx_s2, nx_s3, nx_s4, nx_s5;
	logic [19:0] step2, step3, step4, step5;
	always_comb begin
		step2 = dec_step(st_s1.rem, DEC_W4);
		nx_s2 = st_s1;
		nx_s2.dig[4] = step2[19:16];
		nx_s2.rem = step2[15:0];

		step3 = dec_step(st_s2.rem, DEC_W3);
		nx_s3 = st_s2;
		nx_s3.dig[3] = step3[19:16];
		nx_s3.rem = step3[15:0];

		step4 = dec_step(st_s3.rem, DEC_W2);
		nx_s4 = st_s3;
		nx_s4.dig[2] = step4[19:16];
		nx_s4.rem = step4[15:0];

		step5 = dec_step(st_s4.rem, DEC_W1);
		nx_s5 = st_s4;
		nx_s5.dig[1] = step5[19:16];
		nx_s5.dig[0] = step5[3:0];
		nx_s5.rem = '0;
	end

	// stage 6: character assembly
	char_buf_t c;
	logic [3:0] n;
	logic started;
	logic truth;
	logic [3:0] d;
	always_comb begin
		c = '0;
		n = '0;
		started = st_s5.f.leading_zeros;
		truth = |st_s5.f.value[7:0];
		d = '0;
		case (st_s5.f.kind)
			KIND_DEC: begin
				if (st_s5.neg) begin
					c[n] = CH_MINUS;
					n = n + 4'd1;
				end else if (st_s5.f.force_sign) begin
					c[n] = CH_PLUS;
					n = n + 4'd1;
				end
				for (int i = NUM_DIGITS - 1; i >= 0; i--) begin
					d = st_s5.dig[i];
					// the digit at the point and the ones digit always print
					if (i == int'(st_s5.f.decimal_places) || i == 0 || d != 4'd0)
						started = 1'b1;
					if (started) begin
						c[n] = 7'(CH_0 + {3'b000, d});
						n = n + 4'd1;
					end
					if (i == int'(st_s5.f.decimal_places) && i != 0) begin
						c[n] = CH_POINT;
						n = n + 4'd1;
					end
				end
			end
			KIND_HEX: begin
				if (st_s5.f.hex_prefix) begin
					c[n] = CH_0;
					c[n + 4'd1] = CH_LC_X;
					n = n + 4'd2;
				end
				if (!st_s5.f.hex_byte) begin
					c[n] = hex_char(st_s5.f.value[15:12]);
					c[n + 4'd1] = hex_char(st_s5.f.value[11:8]);
					n = n + 4'd2;
				end
				c[n] = hex_char(st_s5.f.value[7:4]);
				c[n + 4'd1] = hex_char(st_s5.f.value[3:0]);
				n = n + 4'd2;
			end
			KIND_BIN: begin
				if (st_s5.f.binary_prefix) begin
					c[n] = CH_0;
					c[n + 4'd1] = CH_LC_B;
					n = n + 4'd2;
				end
				for (int b = 7; b >= 0; b--) begin
					c[n] = st_s5.f.value[b] ? CH_1 : CH_0;
					n = n + 4'd1;
				end
			end
			KIND_BOOL: begin
				case (st_s5.f.bool_style)
					STYLE_YES_NO: begin
						if (truth) begin
							c[0] = CH_UC_Y; c[1] = CH_LC_E; c[2] = CH_LC_S;
							n = 4'd3;
						end else begin
							c[0] = CH_UC_N; c[1] = CH_LC_O;
							n = 4'd2;
						end
					end
					STYLE_T_F: begin
						c[0] = truth ? CH_UC_T : CH_UC_F;
						n = 4'd1;
					end
					// true/false, also for the undefined fourth style
					default: begin
						if (truth) begin
							c[0] = CH_UC_T; c[1] = CH_LC_R; c[2] = CH_LC_U; c[3] = CH_LC_E;
							n = 4'd4;
						end else begin
							c[0] = CH_UC_F; c[1] = CH_LC_A; c[2] = CH_LC_L;
							c[3] = CH_LC_S; c[4] = CH_LC_E;
							n = 4'd5;
						end
					end
				endcase
			end
			default: begin
				n = '0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			rem_q <= '0;
			strobe_q <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= accept;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
			if (rdy_s6) v_s6 <= v_s5;
			// a new text loads as the previous one sends its last character
			if (ser_take && v_s6)
				rem_q <= len_s6;
			else if (rem_q != 4'd0)
				rem_q <= rem_q - 4'd1;
			strobe_q <= (rem_q != 4'd0);
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (rdy_s1) st_s1 <= nx_s1;
		if (rdy_s2) st_s2 <= nx_s2;
		if (rdy_s3) st_s3 <= nx_s3;
		if (rdy_s4) st_s4 <= nx_s4;
		if (rdy_s5) st_s5 <= nx_s5;
		if (rdy_s6) begin
			chr_s6 <= c;
			len_s6 <= n;
		end
		if (ser_take && v_s6)
			chr_q <= chr_s6;
		else
			chr_q <= {7'd0, chr_q[MAX_CHARS-1:1]};
		char_code_q <= chr_q[0];
		last_q <= (rem_q == 4'd1);
	end

	assign strobe = strobe_q;
	assign char_code = char_code_q;
	assign last = last_q;

	// a character that is not the last is followed by the next one at once
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> strobe)
		else $error("text interrupted before last character");

	// an accepted word always lands in stage 1
	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> v_s1)
		else $error("accepted word lost at stage 1");

	// the shifter never holds more than a full text
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q <= 4'd10)
		else $error("character count out of range");

	// last only marks a real character
	a_last_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		!strobe |-> !last)
		else $error("last without strobe");

endmodule
